>>> sv/dos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference-over-sum package
// Shared widths, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package dos_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int MAG_BITS    = SAMPLE_BITS;
  localparam int SUM_BITS    = SAMPLE_BITS + 1;
  localparam int SCALE_BITS  = 10;
  localparam int THR_BITS    = 12;
  localparam int LIMIT_BITS  = 12;
  localparam int OUT_BITS    = 13;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_IDX_BITS  = 2;

  localparam int PROD_BITS = MAG_BITS + SCALE_BITS;
  localparam int DIV_ITER  = (PROD_BITS + 1) / 2;
  localparam int DIV_BITS  = 2 * DIV_ITER;
  localparam int CNT_BITS  = $clog2(DIV_ITER);

  localparam logic [CFG_IDX_BITS-1:0] REG_WEAK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATIO_SCALE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ERROR_LIMIT    = 2'd2;

  localparam logic [THR_BITS-1:0]   WEAK_THRESHOLD_RST = 12'd300;
  localparam logic [SCALE_BITS-1:0] RATIO_SCALE_RST    = 10'd400;
  localparam logic [LIMIT_BITS-1:0] ERROR_LIMIT_RST    = 12'd500;
  localparam logic signed [DIFF_BITS-1:0] HELD_DIFF_RST = 13'sd500;

  typedef struct packed {
    logic load;
    logic update;
    logic mult;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

>>> sv/dos_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference-over-sum channel interfaces
// Valid/ready channels for sample pairs and for position error results.
// ----------------------------------------------------------------------------
interface dos_in_if;
  logic                             valid;
  logic                             ready;
  logic [dos_pkg::SAMPLE_BITS-1:0]  right_sample;
  logic [dos_pkg::SAMPLE_BITS-1:0]  left_sample;

  modport source (output valid, output right_sample, output left_sample, input ready);
  modport sink   (input valid, input right_sample, input left_sample, output ready);
endinterface

interface dos_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dos_pkg::OUT_BITS-1:0] position_error;

  modport source (output valid, output position_error, input ready);
  modport sink   (input valid, input position_error, output ready);
endinterface

>>> sv/dos_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference-over-sum controller
// Sequences update, multiply, divide and result handoff for one beat.
// ----------------------------------------------------------------------------
module dos_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dos_pkg::dp_cmd_t    cmd_o,
  input  dos_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MULT,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q;
    cmd_o         = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/dos_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference-over-sum datapath
// Holds configuration and the held difference, scales it and divides it by
// the sample sum + 1 with a two-bit-per-cycle restoring divider, then clamps.
// ----------------------------------------------------------------------------
module dos_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dos_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [dos_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic [dos_pkg::SAMPLE_BITS-1:0]     right_sample_i,
  input  logic [dos_pkg::SAMPLE_BITS-1:0]     left_sample_i,
  input  dos_pkg::dp_cmd_t                    cmd_i,
  output dos_pkg::dp_status_t                 status_o,
  output logic signed [dos_pkg::OUT_BITS-1:0] position_error_o
);

  logic [dos_pkg::THR_BITS-1:0]   weak_thr_q;
  logic [dos_pkg::SCALE_BITS-1:0] scale_q;
  logic [dos_pkg::LIMIT_BITS-1:0] limit_q;

  logic [dos_pkg::SAMPLE_BITS-1:0]       right_q, left_q;
  logic signed [dos_pkg::DIFF_BITS-1:0]  held_q, held_d;
  logic [dos_pkg::SUM_BITS-1:0]          sum_q;
  logic                                  neg_q;
  logic [dos_pkg::DIV_BITS-1:0]          quo_q;
  logic [dos_pkg::SUM_BITS-1:0]          rem_q;
  logic [dos_pkg::CNT_BITS-1:0]          cnt_q;
  logic signed [dos_pkg::OUT_BITS-1:0]   res_q, res_d;

  logic signed [dos_pkg::DIFF_BITS-1:0] diff;
  logic [dos_pkg::SAMPLE_BITS-1:0]      smaller;
  logic [dos_pkg::MAG_BITS-1:0]         diff_mag, held_mag;
  logic                                 same_sign;

  logic [dos_pkg::SUM_BITS:0]   trial1, trial2;
  logic [dos_pkg::SUM_BITS-1:0] rem1, rem2;
  logic                         ge1, ge2;

  logic [dos_pkg::MAG_BITS-1:0]   clamp_mag;
  logic [dos_pkg::PROD_BITS-1:0]  prod;

  // Guarded update of the held difference.
  always_comb begin
    diff = $signed({1'b0, right_q}) - $signed({1'b0, left_q});
    smaller = (right_q < left_q) ? right_q : left_q;
    diff_mag = diff[dos_pkg::DIFF_BITS-1] ? dos_pkg::MAG_BITS'(-diff)
                                          : diff[dos_pkg::MAG_BITS-1:0];
    held_mag = held_q[dos_pkg::DIFF_BITS-1] ? dos_pkg::MAG_BITS'(-held_q)
                                            : held_q[dos_pkg::MAG_BITS-1:0];
    same_sign = ((diff > 0) && (held_q > 0)) || ((diff < 0) && (held_q < 0));
    held_d = held_q;
    if (smaller >= weak_thr_q) begin
      held_d = diff;
    end else if ((diff_mag > held_mag) && same_sign) begin
      held_d = diff;
    end
  end

  assign prod = held_mag * scale_q;

  // Two restoring division steps per cycle.
  always_comb begin
    trial1 = {rem_q, quo_q[dos_pkg::DIV_BITS-1]};
    ge1    = (trial1 >= {1'b0, sum_q});
    rem1   = ge1 ? dos_pkg::SUM_BITS'(trial1 - {1'b0, sum_q})
                 : trial1[dos_pkg::SUM_BITS-1:0];
    trial2 = {rem1, quo_q[dos_pkg::DIV_BITS-2]};
    ge2    = (trial2 >= {1'b0, sum_q});
    rem2   = ge2 ? dos_pkg::SUM_BITS'(trial2 - {1'b0, sum_q})
                 : trial2[dos_pkg::SUM_BITS-1:0];
  end

  assign status_o.div_last = (cnt_q == dos_pkg::CNT_BITS'(dos_pkg::DIV_ITER - 1));

  // Clamp the quotient magnitude and restore the sign.
  always_comb begin
    if (quo_q > dos_pkg::DIV_BITS'(limit_q)) begin
      clamp_mag = limit_q;
    end else begin
      clamp_mag = quo_q[dos_pkg::MAG_BITS-1:0];
    end
    res_d = neg_q ? -$signed({1'b0, clamp_mag}) : $signed({1'b0, clamp_mag});
  end

  assign position_error_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weak_thr_q <= dos_pkg::WEAK_THRESHOLD_RST;
      scale_q    <= dos_pkg::RATIO_SCALE_RST;
      limit_q    <= dos_pkg::ERROR_LIMIT_RST;
      held_q     <= dos_pkg::HELD_DIFF_RST;
      cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dos_pkg::REG_WEAK_THRESHOLD: weak_thr_q <= cfg_data_i[dos_pkg::THR_BITS-1:0];
          dos_pkg::REG_RATIO_SCALE:    scale_q    <= cfg_data_i[dos_pkg::SCALE_BITS-1:0];
          dos_pkg::REG_ERROR_LIMIT:    limit_q    <= cfg_data_i[dos_pkg::LIMIT_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.update) begin
        held_q <= held_d;
      end
      if (cmd_i.mult) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      right_q <= right_sample_i;
      left_q  <= left_sample_i;
    end
    if (cmd_i.update) begin
      sum_q <= dos_pkg::SUM_BITS'(right_q) + dos_pkg::SUM_BITS'(left_q) + 1'b1;
    end
    if (cmd_i.mult) begin
      quo_q <= dos_pkg::DIV_BITS'(prod);
      rem_q <= '0;
      neg_q <= held_q[dos_pkg::DIFF_BITS-1];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[dos_pkg::DIV_BITS-3:0], ge1, ge2};
      rem_q <= rem2;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

endmodule

>>> sv/diff_over_sum_position_error_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Difference-over-sum position error
// Takes right/left sensor sample pairs and returns the clamped, scaled ratio
// of a guarded held difference to the sample sum plus one.
// ----------------------------------------------------------------------------
// Each sample pair is handled on its own: after the beat that takes it in, the
// block is not ready for the next pair until it has updated the held difference
// and formed the sum, scaled it, run the radix-4 restoring divider and clamped
// the quotient into the output register. The output register holds a finished
// result while the next pair is taken in; a stalled result delays only the
// clamp step.
// Configuration writes take effect at once and are meant for idle periods.
module diff_over_sum_position_error_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dos_in_if.sink                             in_chan,
  dos_out_if.source                          out_chan,
  input  logic                               cfg_we_i,
  input  logic [dos_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [dos_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  dos_pkg::dp_cmd_t    cmd;
  dos_pkg::dp_status_t status;

  dos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_ready_o  (in_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dos_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .right_sample_i   (in_chan.right_sample),
    .left_sample_i    (in_chan.left_sample),
    .cmd_i            (cmd),
    .status_o         (status),
    .position_error_o (out_chan.position_error)
  );

endmodule
